// ===== src/cpmq_pkg.sv =====
package cpmq_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN
  } state_t;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam int unsigned OP_POP_BIT = 1;

  localparam logic [2:0] STAT_APPENDED = 3'd0;
  localparam logic [2:0] STAT_REPLACED = 3'd1;
  localparam logic [2:0] STAT_DROPPED  = 3'd2;
  localparam logic [2:0] STAT_POPPED   = 3'd3;
  localparam logic [2:0] STAT_EMPTY    = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  priority_req;
    logic [7:0]  action;
    logic [7:0]  first_command;
    logic [7:0]  first_key;
    logic [15:0] first_value;
    logic [7:0]  second_command;
    logic [7:0]  second_key;
    logic [15:0] second_value;
    logic [7:0]  delimiter;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  fill_level;
    logic [3:0]  out_priority;
    logic [7:0]  out_action;
    logic [7:0]  out_first_command;
    logic [7:0]  out_first_key;
    logic [15:0] out_first_value;
    logic [7:0]  out_second_command;
    logic [7:0]  out_second_key;
    logic [15:0] out_second_value;
    logic [7:0]  out_delimiter;
  } out_word_t;

  typedef struct packed {
    logic [3:0]  prio;
    logic [7:0]  act;
    logic [7:0]  c1;
    logic [7:0]  k1;
    logic [7:0]  c2;
    logic [7:0]  k2;
    logic [7:0]  dl;
    logic [15:0] v1;
    logic [15:0] v2;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  function automatic entry_t word_to_entry(input in_word_t w);
    entry_t e;
    e.prio = w.priority_req;
    e.act  = w.action;
    e.c1   = w.first_command;
    e.k1   = w.first_key;
    e.c2   = w.second_command;
    e.k2   = w.second_key;
    e.dl   = w.delimiter;
    e.v1   = w.first_value;
    e.v2   = w.second_value;
    return e;
  endfunction

endpackage

// ===== src/cpmq_ram.sv =====
module cpmq_ram #(
  parameter int unsigned WIDTH = 84,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/coalescing_priority_message_queue_unit.sv =====
// A queue of command messages held in a circular buffer in one synchronous RAM.
// An input word is taken at a rising edge where start is high and busy is low;
// its opcode selects append at the tail, insert with coalescing, or pop of the
// head. Each word gives exactly one result word on out_word, shown for one
// cycle with out_valid high; the receiver cannot stall and need not.
// Append, a pop on an empty queue and an insert into an empty queue are done
// from the idle state. A pop goes through ST_POP to read the head entry from the RAM.
// An insert reads the stored entries one per cycle from the head and stops at
// the first one it may replace, or appends at the tail when none matches; the
// single RAM read port sets the pace of that scan.
// busy falls in the cycle in which the result is shown, so a new word may be
// started while the previous result is on the ports.
// A synchronous active-low reset empties the queue and drops any operation in
// progress; the RAM contents are not cleared, as only entries that have been
// written are ever read.
module coalescing_priority_message_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cpmq_pkg::in_word_t in_word,
  output logic               out_valid,
  output cpmq_pkg::out_word_t out_word
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cpmq_pkg::state_t    state_r, state_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [PTR_W-1:0]    idx_r, idx_nxt;
  cpmq_pkg::in_word_t  msg_r, msg_nxt;
  cpmq_pkg::out_word_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic [PTR_W-1:0]     ram_raddr;
  cpmq_pkg::entry_t     ram_wdata;
  logic [cpmq_pkg::ENTRY_W-1:0] ram_rdata;
  cpmq_pkg::entry_t     rd_entry;

  logic                 is_pop;
  logic                 is_insert;
  logic                 q_empty;
  logic                 q_full;
  logic                 scan_match;
  logic                 scan_more;
  logic [PTR_W-1:0]     tail_addr;

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
    logic [PTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PTR_W + 1)'(QUEUE_DEPTH)) begin
      s = s - (PTR_W + 1)'(QUEUE_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  cpmq_ram #(
    .WIDTH (cpmq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry  = cpmq_pkg::entry_t'(ram_rdata);
  assign is_pop    = in_word.opcode[cpmq_pkg::OP_POP_BIT];
  assign is_insert = (in_word.opcode == cpmq_pkg::OP_INSERT);
  assign q_empty   = (count_r == '0);
  assign q_full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign tail_addr = wrap_add(head_r, count_r[PTR_W-1:0]);

  assign scan_match = (msg_r.priority_req < rd_entry.prio) ||
                      ((msg_r.priority_req == rd_entry.prio) &&
                       (msg_r.first_command == rd_entry.c1) &&
                       (msg_r.second_command == rd_entry.c2));
  assign scan_more  = ((CNT_W'(idx_r) + CNT_W'(1)) < count_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpmq_pkg::ST_IDLE: begin
        if (start) begin
          if (is_pop) begin
            if (!q_empty) begin
              state_nxt = cpmq_pkg::ST_POP;
            end
          end else if (is_insert && !q_empty) begin
            state_nxt = cpmq_pkg::ST_SCAN;
          end
        end
      end
      cpmq_pkg::ST_POP: begin
        state_nxt = cpmq_pkg::ST_IDLE;
      end
      cpmq_pkg::ST_SCAN: begin
        if (scan_match || !scan_more) begin
          state_nxt = cpmq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cpmq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    logic             app_go;
    cpmq_pkg::entry_t app_e;

    app_go        = 1'b0;
    app_e         = cpmq_pkg::word_to_entry(msg_r);
    ram_we        = 1'b0;
    ram_waddr     = tail_addr;
    ram_wdata     = cpmq_pkg::word_to_entry(msg_r);
    ram_raddr     = head_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    msg_nxt       = msg_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;

    case (state_r)
      cpmq_pkg::ST_IDLE: begin
        if (start) begin
          msg_nxt = in_word;
          idx_nxt = '0;
          if (is_pop) begin
            if (q_empty) begin
              out_nxt        = '0;
              out_nxt.status = cpmq_pkg::STAT_EMPTY;
              out_valid_nxt  = 1'b1;
            end
          end else if (!(is_insert && !q_empty)) begin
            app_go = 1'b1;
            app_e  = cpmq_pkg::word_to_entry(in_word);
          end
        end
      end
      cpmq_pkg::ST_POP: begin
        head_nxt                   = wrap_add(head_r, PTR_W'(1));
        count_nxt                  = count_r - CNT_W'(1);
        out_nxt.status             = cpmq_pkg::STAT_POPPED;
        out_nxt.fill_level         = 7'(count_r - CNT_W'(1));
        out_nxt.out_priority       = rd_entry.prio;
        out_nxt.out_action         = rd_entry.act;
        out_nxt.out_first_command  = rd_entry.c1;
        out_nxt.out_first_key      = rd_entry.k1;
        out_nxt.out_first_value    = rd_entry.v1;
        out_nxt.out_second_command = rd_entry.c2;
        out_nxt.out_second_key     = rd_entry.k2;
        out_nxt.out_second_value   = rd_entry.v2;
        out_nxt.out_delimiter      = rd_entry.dl;
        out_valid_nxt              = 1'b1;
      end
      cpmq_pkg::ST_SCAN: begin
        if (scan_match) begin
          ram_we             = 1'b1;
          ram_waddr          = wrap_add(head_r, idx_r);
          out_nxt            = '0;
          out_nxt.status     = cpmq_pkg::STAT_REPLACED;
          out_nxt.fill_level = 7'(count_r);
          out_valid_nxt      = 1'b1;
        end else if (scan_more) begin
          idx_nxt   = idx_r + PTR_W'(1);
          ram_raddr = wrap_add(head_r, idx_r + PTR_W'(1));
        end else begin
          app_go = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (app_go) begin
      out_nxt       = '0;
      out_valid_nxt = 1'b1;
      if (q_full) begin
        out_nxt.status     = cpmq_pkg::STAT_DROPPED;
        out_nxt.fill_level = 7'(count_r);
      end else begin
        ram_we             = 1'b1;
        ram_waddr          = tail_addr;
        ram_wdata          = app_e;
        count_nxt          = count_r + CNT_W'(1);
        out_nxt.status     = cpmq_pkg::STAT_APPENDED;
        out_nxt.fill_level = 7'(count_r + CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpmq_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    msg_r <= msg_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != cpmq_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
